### hdl/ps2s1_pkg.sv
// Package: scan code constants, prefix states, event kinds and shared types.
`default_nettype none
package ps2s1_pkg;

   // Raw scan code bytes with special meaning
   localparam logic [7:0] CODE_E0        = 8'hE0;
   localparam logic [7:0] CODE_E1        = 8'hE1;
   localparam logic [7:0] CODE_PS_MAKE1  = 8'h2A;
   localparam logic [7:0] CODE_PS_MAKE2  = 8'h37;
   localparam logic [7:0] CODE_PS_BRK1   = 8'hB7;
   localparam logic [7:0] CODE_PS_BRK2   = 8'hAA;
   localparam logic [7:0] CODE_RCTRL_MK  = 8'h1D;
   localparam logic [7:0] CODE_RCTRL_BRK = 8'h9D;
   localparam logic [7:0] CODE_RALT_MK   = 8'h38;
   localparam logic [7:0] CODE_RALT_BRK  = 8'hB8;

   // Key indexes (break bit cleared) of the plain modifier keys
   localparam logic [6:0] KEY_LSHIFT = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_LCTRL  = 7'h1D;
   localparam logic [6:0] KEY_LALT   = 7'h38;

   // Prefix states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_E0     = 4'd1;
   localparam logic [3:0] ST_PSM1   = 4'd2;
   localparam logic [3:0] ST_PSM2   = 4'd3;
   localparam logic [3:0] ST_PSB1   = 4'd4;
   localparam logic [3:0] ST_PSB2   = 4'd5;
   localparam logic [3:0] ST_PAUSE1 = 4'd6;
   localparam logic [3:0] ST_PAUSE5 = 4'd10;
   // Pause state minus this base gives the position of the expected byte
   localparam logic [3:0] PAUSE_BASE = 4'd5;
   localparam logic [2:0] PAUSE_LAST = 3'd5;

   // Event kinds
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_PRESS    = 3'd1;
   localparam logic [2:0] EV_PS_MAKE  = 3'd2;
   localparam logic [2:0] EV_PS_BREAK = 3'd3;
   localparam logic [2:0] EV_PAUSE    = 3'd4;
   localparam logic [2:0] EV_EXT      = 3'd5;

   // Modifier flag bit positions
   localparam int M_LS = 0;
   localparam int M_RS = 1;
   localparam int M_LC = 2;
   localparam int M_RC = 3;
   localparam int M_LA = 4;
   localparam int M_RA = 5;

   typedef logic [5:0] mods_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [6:0] key_index;
      logic       shift_level;
      mods_type   mods;
   } result_type;

   // Bytes of the pause sequence E1 1D 45 E1 9D C5, by position
   function automatic logic [7:0] pause_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = 8'hE1;
         3'd1:    b = 8'h1D;
         3'd2:    b = 8'h45;
         3'd3:    b = 8'hE1;
         3'd4:    b = 8'h9D;
         3'd5:    b = 8'hC5;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

### hdl/ps2s1_if.sv
// Interfaces: scan code request channel and decoded event response channel.
`default_nettype none
interface ps2s1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink (input valid, input scan_code, output ready);
endinterface

interface ps2s1_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [6:0] key_index;
   logic       shift_level;
   logic       left_shift;
   logic       right_shift;
   logic       left_ctrl;
   logic       right_ctrl;
   logic       left_alt;
   logic       right_alt;

   modport source (output valid, output event_kind, output key_index, output shift_level,
                   output left_shift, output right_shift, output left_ctrl,
                   output right_ctrl, output left_alt, output right_alt, input ready);
   modport sink (input valid, input event_kind, input key_index, input shift_level,
                 input left_shift, input right_shift, input left_ctrl,
                 input right_ctrl, input left_alt, input right_alt, output ready);
endinterface
`default_nettype wire

### hdl/ps2s1_decode.sv
// Next-state and event logic for one scan code byte.
`default_nettype none
module ps2s1_decode
   import ps2s1_pkg::*;
(
   input  wire logic [3:0] state,
   input  wire mods_type   mods,
   input  wire logic [7:0] code,
   output logic [3:0]      state_next,
   output result_type      result
);

   logic       use_plain;
   logic [7:0] plain_code;
   logic       plain_make;
   logic [6:0] plain_key;
   logic [2:0] pause_pos;
   mods_type   mods_next;

   assign plain_make = ~plain_code[7];
   assign plain_key  = plain_code[6:0];
   assign pause_pos  = 3'(state - PAUSE_BASE);

   always_comb begin
      state_next         = ST_IDLE;
      mods_next          = mods;
      use_plain          = 1'b0;
      plain_code         = code;
      result.event_kind  = EV_NONE;
      result.key_index   = '0;
      result.shift_level = 1'b0;

      // Walk the prefix state
      unique case (state) inside
         ST_E0: begin
            result.event_kind = EV_EXT;
            unique case (code)
               CODE_PS_MAKE1: begin
                  state_next        = ST_PSM1;
                  result.event_kind = EV_NONE;
               end
               CODE_PS_BRK1: begin
                  state_next        = ST_PSB1;
                  result.event_kind = EV_NONE;
               end
               CODE_RCTRL_MK:  mods_next[M_RC] = 1'b1;
               CODE_RCTRL_BRK: mods_next[M_RC] = 1'b0;
               CODE_RALT_MK:   mods_next[M_RA] = 1'b1;
               CODE_RALT_BRK:  mods_next[M_RA] = 1'b0;
               default: ;
            endcase
         end
         ST_PSM1: begin
            if (code == CODE_E0) begin
               state_next = ST_PSM2;
            end else begin
               use_plain  = 1'b1;
               plain_code = CODE_PS_MAKE1;
            end
         end
         ST_PSM2: begin
            if (code == CODE_PS_MAKE2) begin
               result.event_kind = EV_PS_MAKE;
            end else begin
               use_plain  = 1'b1;
               plain_code = CODE_PS_MAKE1;
            end
         end
         ST_PSB1: begin
            if (code == CODE_E0) begin
               state_next = ST_PSB2;
            end else begin
               use_plain  = 1'b1;
               plain_code = CODE_PS_BRK1;
            end
         end
         ST_PSB2: begin
            if (code == CODE_PS_BRK2) begin
               result.event_kind = EV_PS_BREAK;
            end else begin
               use_plain  = 1'b1;
               plain_code = CODE_PS_BRK1;
            end
         end
         [ST_PAUSE1:ST_PAUSE5]: begin
            // Drop the byte and go idle on a mismatch
            if (code == pause_byte(pause_pos)) begin
               if (pause_pos == PAUSE_LAST) begin
                  result.event_kind = EV_PAUSE;
               end else begin
                  state_next = state + 4'd1;
               end
            end
         end
         default: begin
            // Idle, and any unused code behaves as idle
            if (code == CODE_E1) begin
               state_next = ST_PAUSE1;
            end else if (code == CODE_E0) begin
               state_next = ST_E0;
            end else begin
               use_plain = 1'b1;
            end
         end
      endcase

      // Handle an ordinary code: modifier update or key press
      if (use_plain) begin
         case (plain_key)
            KEY_LSHIFT: mods_next[M_LS] = plain_make;
            KEY_RSHIFT: mods_next[M_RS] = plain_make;
            KEY_LCTRL:  mods_next[M_LC] = plain_make;
            KEY_LALT:   mods_next[M_LA] = plain_make;
            default: begin
               if (plain_make) begin
                  result.event_kind  = EV_PRESS;
                  result.key_index   = plain_key;
                  result.shift_level = mods[M_LS] | mods[M_RS];
               end
            end
         endcase
      end

      result.mods = mods_next;
   end

endmodule
`default_nettype wire

### hdl/ps2_scancode_set1_decoder.sv
// Top level: set-1 scan code decoder with input register and result register.
// An accepted byte waits in the input register until the response register is free.
// Throughput: one request per cycle, limited only by the response side's ready.
// The prefix state and modifier flags update once per byte, in request order.
// Synchronous active-high reset: prefix idle, all modifiers clear, both stages empty.
`default_nettype none
module ps2_scancode_set1_decoder
   import ps2s1_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   ps2s1_req_if.sink   req,
   ps2s1_rsp_if.source rsp
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] code_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;
   logic [3:0] state_ff, state_in;
   mods_type   mods_ff, mods_in;
   logic       advance;
   logic [3:0] dec_state;
   result_type dec_result;

   // Move the held byte on when the response register is free or draining
   assign advance     = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready   = ~in_valid_ff | advance;
   assign in_valid_in = req.valid | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp.ready);

   ps2s1_decode u_decode (
      .state      (state_ff),
      .mods       (mods_ff),
      .code       (code_ff),
      .state_next (dec_state),
      .result     (dec_result)
   );

   assign state_in  = advance ? dec_state : state_ff;
   assign mods_in   = advance ? dec_result.mods : mods_ff;
   assign result_in = advance ? dec_result : result_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         mods_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         mods_ff      <= mods_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.ready) begin
         code_ff <= req.scan_code;
      end
      result_ff <= result_in;
   end

   // Drive the response channel
   assign rsp.valid       = out_valid_ff;
   assign rsp.event_kind  = result_ff.event_kind;
   assign rsp.key_index   = result_ff.key_index;
   assign rsp.shift_level = result_ff.shift_level;
   assign rsp.left_shift  = result_ff.mods[M_LS];
   assign rsp.right_shift = result_ff.mods[M_RS];
   assign rsp.left_ctrl   = result_ff.mods[M_LC];
   assign rsp.right_ctrl  = result_ff.mods[M_RC];
   assign rsp.left_alt    = result_ff.mods[M_LA];
   assign rsp.right_alt   = result_ff.mods[M_RA];

   // Key index and shift level only accompany a key press
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.event_kind != EV_PRESS) |-> (rsp.key_index == 7'd0 &&
      rsp.shift_level == 1'b0))
      else $error("key fields set on a non-press event");

   // A pause event only closes from the last pause state
   assert property (@(posedge clock) disable iff (reset)
      (advance && dec_result.event_kind == EV_PAUSE) |-> (state_ff == ST_PAUSE5))
      else $error("pause event outside the pause sequence");

   // The prefix state never leaves the used codes
   assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_PAUSE5)
      else $error("prefix state out of range");

   // A held byte that cannot advance blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req.ready)
      else $error("request taken while input register is blocked");

endmodule
`default_nettype wire
